[sv/pwmcap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pwmcap_pkg;

  // fixed field widths
  localparam int CH_W      = 3;
  localparam int CNT_IN_W  = 32;
  localparam int TICK_W    = 10;
  localparam int TIME_W    = 39;
  localparam int FREQ_W    = 30;
  localparam int DUTY_W    = 14;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // divider dividend is wide enough for high time times full duty scale
  localparam int DIVD_W    = TIME_W + DUTY_W;
  localparam int DIV_CNT_W = 6;

  // quotient bits produced for each division
  localparam logic [DIV_CNT_W-1:0] ITERS_FREQ  = DIV_CNT_W'(FREQ_W);
  localparam logic [DIV_CNT_W-1:0] ITERS_DUTY  = DIV_CNT_W'(DUTY_W);

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(125);
  localparam logic [TIME_W-1:0] TICK_DIV   = TIME_W'(10);
  localparam logic [FREQ_W-1:0] NS_PER_S   = FREQ_W'(1000000000);
  localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(10000);

  // register index taken from paddr above the word offset
  localparam logic REG_TICK = 1'b0;

  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_NUM_CHANNELS = 6;
  localparam int DEF_COUNT_BITS   = 32;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [CNT_IN_W-1:0] count;
    logic                rising;
    logic                in_range;
  } cap_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

[sv/pwmcap_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pwmcap_in_if;
  logic                               valid;
  logic                               ready;
  logic [pwmcap_pkg::CH_W-1:0]        channel;
  logic [pwmcap_pkg::CNT_IN_W-1:0]    capture_count;
  logic                               level_high;

  modport source (output valid, channel, capture_count, level_high, input ready);
  modport sink (input valid, channel, capture_count, level_high, output ready);
endinterface

interface pwmcap_out_if;
  logic                               valid;
  logic                               ready;
  logic [pwmcap_pkg::CH_W-1:0]        out_channel;
  logic                               was_rising;
  logic [pwmcap_pkg::TIME_W-1:0]      period_ns;
  logic [pwmcap_pkg::TIME_W-1:0]      high_ns;
  logic [pwmcap_pkg::FREQ_W-1:0]      freq_hz;
  logic [pwmcap_pkg::DUTY_W-1:0]      duty_centi_pct;
  logic                               period_valid;

  modport source (output valid, out_channel, was_rising, period_ns, high_ns, freq_hz,
                  duty_centi_pct, period_valid, input ready);
  modport sink (input valid, out_channel, was_rising, period_ns, high_ns, freq_hz,
                duty_centi_pct, period_valid, output ready);
endinterface

`default_nettype wire

[sv/pwm_capture_period_duty_meter_core.sv]
// PWM capture meter: each capture beat (channel, latched timer count, pin level after
// the edge) yields one result beat with the channel's stored period and high time in ns,
// the frequency in Hz and the duty in hundredths of a percent (saturated at 10000).
// A rising edge measures the period since that channel's previous rising edge, a falling
// edge the high time since it; equal counts stand for one full counter wrap, and ticks are
// scaled by tick_tenth_ns / 10, the divide by ten being a shift-and-add estimate with one
// correction step. Captures are classified and queued in front (two entries) so the input
// keeps flowing, until the queue is full, while the back end works and while a result waits
// to be taken. The back end handles one capture at a time; frequency and duty share one
// bit-serial divider, one quotient bit per cycle. The result beat is loaded after the scaling
// steps when the period stays zero, after the frequency division when the duty saturates,
// and after both divisions otherwise; an out-of-range channel reports zeros without scaling
// or dividing. The back end returns to idle as a result is loaded and then takes the next
// queued capture; loading waits while the previous result beat is still untaken. Per-channel
// state lives in flip-flops and is cleared by reset at once. The tick register sits at byte
// address 0 of the APB port and may be rewritten only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pwm_capture_period_duty_meter_core #(
  parameter int NUM_CHANNELS = pwmcap_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = pwmcap_pkg::DEF_COUNT_BITS
) (
  input  wire                              clk,
  input  wire                              rst,
  pwmcap_in_if.sink                        capture,
  pwmcap_out_if.source                     result,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [pwmcap_pkg::APB_AW-1:0]     paddr,
  input  wire [pwmcap_pkg::APB_DW-1:0]     pwdata,
  output logic [pwmcap_pkg::APB_DW-1:0]    prdata,
  output logic                             pready
);

  // tick length register
  logic [pwmcap_pkg::TICK_W-1:0] tick;
  logic                          tick_hit;

  assign pready   = 1'b1;
  assign tick_hit = (paddr[2] == pwmcap_pkg::REG_TICK);
  assign prdata   = tick_hit ? pwmcap_pkg::APB_DW'(tick) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= pwmcap_pkg::TICK_RESET;
    end else if (psel && penable && pwrite && pready && tick_hit) begin
      tick <= pwdata[pwmcap_pkg::TICK_W-1:0];
    end
  end

  // front: accept and classify captures into the queue
  logic                   q_valid;
  logic                   q_pop;
  pwmcap_pkg::cap_item_t  q_item;

  pwmcap_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .capture (capture),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // shared serial divider: frequency and duty
  pwmcap_pkg::div_ctl_t             div_ctl;
  pwmcap_pkg::div_sts_t             div_sts;
  logic [pwmcap_pkg::DIVD_W-1:0]    div_dividend;
  logic [pwmcap_pkg::TIME_W-1:0]    div_divisor;
  logic [pwmcap_pkg::TIME_W-1:0]    div_quo;

  pwmcap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // back: per-channel state, scaling, sequencing of the divisions, result register
  pwmcap_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result       (result),
    .div_ctl      (div_ctl),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quo      (div_quo)
  );

endmodule

`default_nettype wire

[sv/pwmcap_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pwmcap_front #(
  parameter int NUM_CHANNELS = pwmcap_pkg::DEF_NUM_CHANNELS
) (
  input  wire                    clk,
  input  wire                    rst,
  pwmcap_in_if.sink              capture,
  output logic                   q_valid,
  output pwmcap_pkg::cap_item_t  q_item,
  input  wire                    q_pop
);

  localparam int QD   = pwmcap_pkg::QUEUE_DEPTH;
  localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;

  pwmcap_pkg::cap_item_t entries [QD];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   fill;
  logic            push;
  pwmcap_pkg::cap_item_t item_in;

  assign capture.ready = (fill != (QP_W+1)'(QD));
  assign push          = capture.valid && capture.ready;
  assign q_valid       = (fill != '0);
  assign q_item        = entries[rd_ptr];

  // classify the beat on the way in
  always_comb begin
    item_in.channel  = capture.channel;
    item_in.count    = capture.capture_count;
    item_in.rising   = capture.level_high;
    item_in.in_range = (32'(capture.channel) < 32'(NUM_CHANNELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= item_in;
        wr_ptr <= (wr_ptr == QP_W'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == QP_W'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop && q_valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/pwmcap_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module pwmcap_div (
  input  wire                                clk,
  input  wire                                rst,
  input  pwmcap_pkg::div_ctl_t               ctl,
  input  wire [pwmcap_pkg::DIVD_W-1:0]       dividend,
  input  wire [pwmcap_pkg::TIME_W-1:0]       divisor,
  output pwmcap_pkg::div_sts_t               sts,
  output logic [pwmcap_pkg::TIME_W-1:0]      quotient
);

  localparam int DW = pwmcap_pkg::DIVD_W;
  localparam int TW = pwmcap_pkg::TIME_W;

  logic [TW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [pwmcap_pkg::DIV_CNT_W-1:0] cnt;
  logic          busy;
  logic          done;
  logic [TW:0]   trial;
  logic          fits;
  logic [TW-1:0] rem_step;
  logic [TW-1:0] quotient_r;

  // one restoring step per cycle; remainder always stays below divisor
  always_comb begin
    trial    = {rem, dsr[DW-1]};
    fits     = (trial >= {1'b0, divisor});
    rem_step = fits ? TW'(trial - {1'b0, divisor}) : trial[TW-1:0];
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quotient_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pwmcap_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      // upper part goes straight to the remainder, the rest is shifted in
      rem        <= TW'(dividend >> ctl.iters);
      dsr        <= dividend << (DW - 32'(ctl.iters));
      quotient_r <= '0;
    end else if (busy) begin
      rem        <= rem_step;
      dsr        <= {dsr[DW-2:0], 1'b0};
      quotient_r <= {quotient_r[TW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[sv/pwmcap_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pwmcap_back #(
  parameter int NUM_CHANNELS = pwmcap_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = pwmcap_pkg::DEF_COUNT_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [pwmcap_pkg::TICK_W-1:0]        tick,
  input  wire                                 q_valid,
  input  pwmcap_pkg::cap_item_t               q_item,
  output logic                                q_pop,
  pwmcap_out_if.source                        result,
  output pwmcap_pkg::div_ctl_t                div_ctl,
  output logic [pwmcap_pkg::DIVD_W-1:0]       div_dividend,
  output logic [pwmcap_pkg::TIME_W-1:0]       div_divisor,
  input  pwmcap_pkg::div_sts_t                div_sts,
  input  wire [pwmcap_pkg::TIME_W-1:0]        div_quo
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W = COUNT_BITS + 1 + pwmcap_pkg::TICK_W;
  localparam int TW     = pwmcap_pkg::TIME_W;
  localparam int DW     = pwmcap_pkg::DIVD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RCP1  = 4'd1;
  localparam logic [3:0] S_RCP2  = 4'd2;
  localparam logic [3:0] S_RCP3  = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_FREQ  = 4'd6;
  localparam logic [3:0] S_DUTY  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;

  logic [COUNT_BITS-1:0] last_rise   [NUM_CHANNELS];
  logic [TW-1:0]         period_st   [NUM_CHANNELS];
  logic [TW-1:0]         high_st     [NUM_CHANNELS];

  pwmcap_pkg::cap_item_t item_r;
  logic [TW-1:0] per_r;
  logic [TW-1:0] hi_r;
  logic [pwmcap_pkg::FREQ_W-1:0] freq_r;
  logic [pwmcap_pkg::DUTY_W-1:0] duty_r;
  logic          valid_r;
  logic [TW-1:0] dvsr;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] rcp_r;
  logic [TW-1:0]     tns_r;

  logic                           res_valid;
  logic [pwmcap_pkg::CH_W-1:0]    res_ch;
  logic                           res_rising;
  logic [TW-1:0]                  res_per;
  logic [TW-1:0]                  res_hi;
  logic [pwmcap_pkg::FREQ_W-1:0]  res_freq;
  logic [pwmcap_pkg::DUTY_W-1:0]  res_duty;
  logic                           res_pv;

  logic [IDX_W+2:0]      ext_q;
  logic [IDX_W+2:0]      ext_r;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      idx_r;
  logic [COUNT_BITS-1:0] dlow;
  logic [COUNT_BITS:0]   diff;
  logic [PROD_W-1:0]     scaled;
  logic [PROD_W-1:0]     rcp_a;
  logic [PROD_W-1:0]     rcp_b;
  logic [PROD_W-1:0]     rcp_c;
  logic [PROD_W-1:0]     rcp_d;
  logic [PROD_W-1:0]     rcp_e;
  logic [PROD_W-1:0]     rem10;
  logic [PROD_W-1:0]     scale_q;
  logic [TW-1:0]         per_n;
  logic [TW-1:0]         hi_n;

  assign ext_q = (IDX_W+3)'(q_item.channel);
  assign ext_r = (IDX_W+3)'(item_r.channel);
  assign idx_q = ext_q[IDX_W-1:0];
  assign idx_r = ext_r[IDX_W-1:0];

  // tick difference modulo the counter width, equal counts mean a full wrap
  always_comb begin
    dlow   = q_item.count[COUNT_BITS-1:0] - last_rise[idx_q];
    diff   = (dlow == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, dlow};
    scaled = PROD_W'(diff) * PROD_W'(tick);
    // divide by ten: 0.8 * x by shift-and-add, then over eight, then one fix step
    rcp_a   = (prod_r >> 1) + (prod_r >> 2);
    rcp_b   = rcp_a + (rcp_a >> 4);
    rcp_c   = rcp_r + (rcp_r >> 8);
    rcp_d   = rcp_c + (rcp_c >> 16);
    rcp_e   = rcp_r + (rcp_r >> 32);
    // estimate is low by at most one
    rem10   = prod_r - ((rcp_r << 3) + (rcp_r << 1));
    scale_q = rcp_r + PROD_W'(rem10 >= PROD_W'(pwmcap_pkg::TICK_DIV));
    per_n   = item_r.rising ? tns_r : period_st[idx_r];
    hi_n    = item_r.rising ? high_st[idx_r] : tns_r;
  end

  assign q_pop       = (state == S_IDLE) && q_valid;
  assign div_divisor = dvsr;

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.iters = '0;
    div_dividend  = '0;
    case (state)
      S_SCALE: begin
        if (per_n != '0) begin
          div_ctl.start = 1'b1;
          div_ctl.iters = pwmcap_pkg::ITERS_FREQ;
          div_dividend  = DW'(pwmcap_pkg::NS_PER_S);
        end
      end
      S_FREQ: begin
        // duty below full scale only; otherwise it saturates without dividing
        if (div_sts.done && (hi_r < per_r)) begin
          div_ctl.start = 1'b1;
          div_ctl.iters = pwmcap_pkg::ITERS_DUTY;
          div_dividend  = DW'(hi_r) * DW'(pwmcap_pkg::DUTY_FULL);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_rise[i] <= '0;
        period_st[i] <= '0;
        high_st[i]   <= '0;
      end
    end else begin
      if ((state == S_DONE) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item_r <= q_item;
            if (q_item.in_range) begin
              prod_r <= scaled;
              state  <= S_RCP1;
            end else begin
              per_r   <= '0;
              hi_r    <= '0;
              freq_r  <= '0;
              duty_r  <= '0;
              valid_r <= 1'b0;
              state   <= S_DONE;
            end
          end
        end
        S_RCP1: begin
          rcp_r <= rcp_b;
          state <= S_RCP2;
        end
        S_RCP2: begin
          rcp_r <= rcp_d;
          state <= S_RCP3;
        end
        S_RCP3: begin
          rcp_r <= rcp_e >> 3;
          state <= S_FIX;
        end
        S_FIX: begin
          tns_r <= TW'(scale_q);
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (item_r.rising) begin
            period_st[idx_r] <= tns_r;
            last_rise[idx_r] <= item_r.count[COUNT_BITS-1:0];
          end else begin
            high_st[idx_r] <= tns_r;
          end
          per_r   <= per_n;
          hi_r    <= hi_n;
          freq_r  <= '0;
          duty_r  <= '0;
          valid_r <= (per_n != '0);
          dvsr    <= per_n;
          state   <= (per_n != '0) ? S_FREQ : S_DONE;
        end
        S_FREQ: begin
          if (div_sts.done) begin
            freq_r <= div_quo[pwmcap_pkg::FREQ_W-1:0];
            if (hi_r >= per_r) begin
              duty_r <= pwmcap_pkg::DUTY_FULL;
              state  <= S_DONE;
            end else begin
              state <= S_DUTY;
            end
          end
        end
        S_DUTY: begin
          if (div_sts.done) begin
            duty_r <= div_quo[pwmcap_pkg::DUTY_W-1:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_ch     <= item_r.channel;
            res_rising <= item_r.rising;
            res_per    <= per_r;
            res_hi     <= hi_r;
            res_freq   <= freq_r;
            res_duty   <= duty_r;
            res_pv     <= valid_r;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.out_channel    = res_ch;
  assign result.was_rising     = res_rising;
  assign result.period_ns      = res_per;
  assign result.high_ns        = res_hi;
  assign result.freq_hz        = res_freq;
  assign result.duty_centi_pct = res_duty;
  assign result.period_valid   = res_pv;

endmodule

`default_nettype wire
